### hw/rtl/adpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpd_pkg: shared types and constants of the ASF data packet deframer
// Parse phases, result kinds, register indexes and the result record.
// ----------------------------------------------------------------------------
package adpd_pkg;

    typedef enum logic [4:0] {
        PH_EC      = 5'd0,
        PH_ECDATA  = 5'd1,
        PH_FLAGS   = 5'd2,
        PH_PROP    = 5'd3,
        PH_LEN     = 5'd4,
        PH_SEQ     = 5'd5,
        PH_PAD     = 5'd6,
        PH_SEND    = 5'd7,
        PH_DUR     = 5'd8,
        PH_PCOUNT  = 5'd9,
        PH_STREAM  = 5'd10,
        PH_OBJNUM  = 5'd11,
        PH_OBJOFF  = 5'd12,
        PH_REPLEN  = 5'd13,
        PH_REP     = 5'd14,
        PH_DELTA   = 5'd15,
        PH_PLEN    = 5'd16,
        PH_SUBLEN  = 5'd17,
        PH_DATA    = 5'd18,
        PH_SKIP    = 5'd19,
        PH_DISCARD = 5'd20
    } t_phase;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_HDR_ERR = 2'd1;
    localparam logic [1:0] KIND_PAY_ERR = 2'd2;

    localparam logic [1:0] REG_PACKET_SIZE  = 2'd0;
    localparam logic [1:0] REG_PREROLL      = 2'd1;
    localparam logic [1:0] REG_PREROLL_START = 2'd2;
    localparam logic [1:0] REG_START_FIRST  = 2'd3;

    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
    localparam int          QDEPTH = 4;
    localparam int          QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  payload_byte;
        logic [6:0]  stream_id;
        logic        key_frame;
        logic        frag_first;
        logic        frag_last;
        logic [31:0] object_number;
        logic [31:0] object_offset;
        logic [39:0] pts_ms;
        logic [31:0] dts_ms;
        logic [31:0] send_ms;
        logic        preroll_done;
    } t_result;

    function automatic logic [2:0] fsize(input logic [1:0] t);
        case (t)
            2'd1:    fsize = 3'd1;
            2'd2:    fsize = 3'd2;
            2'd3:    fsize = 3'd4;
            default: fsize = 3'd0;
        endcase
    endfunction

endpackage

### hw/rtl/adpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpd_parser: byte parser of the deframer
// Walks the packet and payload headers one byte a cycle while i_valid is high,
// and produces at most one result record per byte.
// ----------------------------------------------------------------------------
module adpd_parser
    import adpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_packet_size,
    input  logic [31:0] i_preroll_ms,
    input  logic [31:0] i_preroll_start_ms,
    input  logic        i_start_from_first,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [32:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [31:0] r_pbl, n_pbl;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_fbl, n_fbl;
    logic [2:0]  r_fidx, n_fidx;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_prop, n_prop;
    logic [31:0] r_pad, n_pad;
    logic [31:0] r_send, n_send;
    logic [5:0]  r_pl, n_pl;
    logic [1:0]  r_plt, n_plt;
    logic [31:0] r_payl, n_payl;
    logic [31:0] r_sub, n_sub;
    logic [39:0] r_sit, n_sit;
    logic [7:0]  r_step, n_step;
    logic [31:0] r_ptime, n_ptime;
    logic [6:0]  r_stream, n_stream;
    logic        r_key, n_key;
    logic [31:0] r_onum, n_onum;
    logic [31:0] r_ooff, n_ooff;
    logic [31:0] r_rlen, n_rlen;
    logic [31:0] r_ridx, n_ridx;
    logic [31:0] r_org, n_org;
    logic        r_orgv, n_orgv;
    logic        r_pflag, n_pflag;
    logic        r_first, n_first;
    logic [1:0]  ev;
    t_result     res_data;

    // Working copies inside the combinational step
    logic [32:0] pos;
    logic [31:0] plen;
    logic [31:0] rm;
    logic [40:0] sitsum;
    logic [40:0] ptssum;
    logic [32:0] orgsum;
    logic [31:0] org;
    logic [32:0] tval;
    logic [31:0] v;
    logic [31:0] tmp;
    logic [2:0]  n;

    always_comb begin
        n_phase = r_phase;  n_pos = r_pos;    n_len = r_len;   n_pbl = r_pbl;
        n_acc = r_acc;      n_fbl = r_fbl;    n_fidx = r_fidx; n_flags = r_flags;
        n_prop = r_prop;    n_pad = r_pad;    n_send = r_send; n_pl = r_pl;
        n_plt = r_plt;      n_payl = r_payl;  n_sub = r_sub;   n_sit = r_sit;
        n_step = r_step;    n_ptime = r_ptime; n_stream = r_stream; n_key = r_key;
        n_onum = r_onum;    n_ooff = r_ooff;  n_rlen = r_rlen; n_ridx = r_ridx;
        n_org = r_org;      n_orgv = r_orgv;  n_pflag = r_pflag; n_first = r_first;
        ev = 2'd0;
        res_data = '0;
        sitsum = '0; ptssum = '0; orgsum = '0; org = '0; tval = '0;
        v = '0; tmp = '0; n = '0;
        pos = (r_phase == PH_EC) ? 33'd1 : r_pos + 33'd1;
        plen = (r_phase == PH_EC) ? {16'd0, i_packet_size} : r_len;
        n_len = plen;
        rm = ({1'b0, plen} > pos) ? plen - pos[31:0] : 32'd0;

        // Per-phase decoding, producing a "go" request
        // Actions are encoded as a small sequence resolved below.
        begin : step
            logic go_hdr, go_disc, go_pay, go_enter, go_len_chk, go_after_time;
            logic go_objnum, go_objoff, go_replen, go_after_replen, go_pad;
            logic go_after_pad, go_seq, go_next_sub, go_len, go_dur;
            logic [31:0] chk;
            go_hdr = 1'b0; go_disc = 1'b0; go_pay = 1'b0; go_enter = 1'b0;
            go_len_chk = 1'b0; go_after_time = 1'b0; go_objnum = 1'b0;
            go_objoff = 1'b0; go_replen = 1'b0; go_after_replen = 1'b0;
            go_pad = 1'b0; go_after_pad = 1'b0; go_seq = 1'b0; go_next_sub = 1'b0;
            go_len = 1'b0; go_dur = 1'b0;
            chk = '0;

            case (r_phase)
                PH_EC: begin
                    if (i_byte[7]) begin
                        if (i_byte[6:5] != 2'd0 || i_byte[4] || i_byte[3:0] != 4'h2)
                            go_hdr = 1'b1;
                        else begin
                            n_phase = PH_ECDATA;
                            n_fbl = 3'd2;
                        end
                    end else if (i_packet_size <= 16'd2) begin
                        go_hdr = 1'b1;
                    end else begin
                        n_flags = i_byte;
                        n_phase = PH_PROP;
                    end
                end
                PH_ECDATA: begin
                    n_fbl = (r_fbl != 3'd0) ? r_fbl - 3'd1 : 3'd0;
                    if (n_fbl == 3'd0) begin
                        if (pos + 33'd2 >= {17'd0, i_packet_size}) go_hdr = 1'b1;
                        else n_phase = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    n_flags = i_byte;
                    n_phase = PH_PROP;
                end
                PH_PROP: begin
                    n_prop = i_byte;
                    go_len = 1'b1;
                end
                PH_PCOUNT: begin
                    n_pl = i_byte[5:0];
                    n_plt = i_byte[7:6];
                    go_enter = 1'b1;
                end
                PH_STREAM: begin
                    n_key = i_byte[7];
                    n_stream = i_byte[6:0];
                    if (r_pl != 6'd0) n_pl = r_pl - 6'd1;
                    go_objnum = 1'b1;
                end
                PH_REP: begin
                    if (r_ridx >= 32'd4 && r_ridx < 32'd8) begin
                        case (r_ridx[1:0])
                            2'd0:    n_acc[7:0]   = i_byte;
                            2'd1:    n_acc[15:8]  = i_byte;
                            2'd2:    n_acc[23:16] = i_byte;
                            default: n_acc[31:24] = i_byte;
                        endcase
                    end
                    n_ridx = r_ridx + 32'd1;
                    if (n_ridx >= r_rlen) begin
                        n_step = 8'd0;
                        tval = {1'b0, n_acc} - {1'b0, i_preroll_ms};
                        go_after_time = 1'b1;
                    end
                end
                PH_DELTA: begin
                    n_step = i_byte;
                    tval = {1'b0, r_ooff} - {1'b0, i_preroll_ms};
                    n_ooff = '0;
                    go_after_time = 1'b1;
                end
                PH_SUBLEN: begin
                    tmp = (r_payl != 32'd0) ? r_payl - 32'd1 : 32'd0;
                    n_payl = tmp;
                    if ({24'd0, i_byte} > tmp) begin
                        n_payl = '0;
                        if (tmp == 32'd0) go_enter = 1'b1;
                        else begin
                            n_sub = tmp;
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        n_payl = tmp - {24'd0, i_byte};
                        n_sub = {24'd0, i_byte};
                        if (i_byte == 8'd0) begin
                            sitsum = {1'b0, r_sit} + {33'd0, r_step};
                            n_sit = (sitsum > {1'b0, MAX40}) ? MAX40 : sitsum[39:0];
                            go_next_sub = 1'b1;
                        end else begin
                            n_first = 1'b1;
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    ptssum = {9'd0, r_ptime} + {1'b0, r_sit};
                    res_data.out_kind = KIND_DATA;
                    res_data.payload_byte = i_byte;
                    res_data.stream_id = r_stream;
                    res_data.key_frame = r_key;
                    res_data.frag_first = r_first;
                    res_data.frag_last = (r_sub <= 32'd1);
                    res_data.object_number = r_onum;
                    res_data.object_offset = r_ooff;
                    res_data.pts_ms = (ptssum > {1'b0, MAX40}) ? MAX40 : ptssum[39:0];
                    res_data.dts_ms = r_ptime;
                    res_data.send_ms = r_send;
                    res_data.preroll_done = r_pflag;
                    ev = 2'd1;
                    n_first = 1'b0;
                    n_sub = (r_sub != 32'd0) ? r_sub - 32'd1 : 32'd0;
                    if (n_sub == 32'd0) begin
                        sitsum = {1'b0, r_sit} + {33'd0, r_step};
                        n_sit = (sitsum > {1'b0, MAX40}) ? MAX40 : sitsum[39:0];
                        go_next_sub = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_sub = (r_sub != 32'd0) ? r_sub - 32'd1 : 32'd0;
                    if (n_sub == 32'd0) go_enter = 1'b1;
                end
                PH_DISCARD: begin
                    n_pbl = (r_pbl != 32'd0) ? r_pbl - 32'd1 : 32'd0;
                    if (n_pbl == 32'd0) n_phase = PH_EC;
                end
                default: begin
                    case (r_fidx)
                        3'd0:    n_acc[7:0]   = i_byte;
                        3'd1:    n_acc[15:8]  = i_byte;
                        3'd2:    n_acc[23:16] = i_byte;
                        3'd3:    n_acc[31:24] = i_byte;
                        default: n_acc = r_acc;
                    endcase
                    if (r_fidx < 3'd4) n_fidx = r_fidx + 3'd1;
                    n_fbl = (r_fbl != 3'd0) ? r_fbl - 3'd1 : 3'd0;
                    if (n_fbl == 3'd0) begin
                        v = n_acc;
                        case (r_phase)
                            PH_LEN: begin
                                plen = v; n_len = v;
                                rm = ({1'b0, plen} > pos) ? plen - pos[31:0] : 32'd0;
                                go_seq = 1'b1;
                            end
                            PH_SEQ: go_pad = 1'b1;
                            PH_PAD: begin
                                n_pad = v;
                                go_after_pad = 1'b1;
                            end
                            PH_SEND: begin
                                n_send = v;
                                n_phase = PH_DUR; n_fbl = 3'd2; n_acc = '0; n_fidx = '0;
                            end
                            PH_DUR: go_dur = 1'b1;
                            PH_OBJNUM: begin
                                n_onum = v;
                                go_objoff = 1'b1;
                            end
                            PH_OBJOFF: begin
                                n_ooff = v;
                                go_replen = 1'b1;
                            end
                            PH_REPLEN: begin
                                n_rlen = v;
                                go_after_replen = 1'b1;
                            end
                            default: begin
                                chk = v;
                                go_len_chk = 1'b1;
                            end
                        endcase
                    end
                end
            endcase

            // Packet header chain
            if (go_len) begin
                n = fsize(n_flags[6:5]);
                plen = {16'd0, i_packet_size}; n_len = plen;
                rm = ({1'b0, plen} > pos) ? plen - pos[31:0] : 32'd0;
                if (n == 3'd0) go_seq = 1'b1;
                else if (pos + {30'd0, n} > {17'd0, i_packet_size}) go_hdr = 1'b1;
                else begin
                    n_phase = PH_LEN; n_fbl = n; n_acc = '0; n_fidx = '0;
                end
            end
            if (go_seq) begin
                n = fsize(n_flags[2:1]);
                if (n == 3'd0) go_pad = 1'b1;
                else if (pos + {30'd0, n} > {17'd0, i_packet_size}) go_hdr = 1'b1;
                else begin
                    n_phase = PH_SEQ; n_fbl = n; n_acc = '0; n_fidx = '0;
                end
            end
            if (go_pad) begin
                n = fsize(n_flags[4:3]);
                n_pad = '0;
                if (n == 3'd0) go_after_pad = 1'b1;
                else if (pos + {30'd0, n} > {17'd0, i_packet_size}) go_hdr = 1'b1;
                else begin
                    n_phase = PH_PAD; n_fbl = n; n_acc = '0; n_fidx = '0;
                end
            end
            if (go_after_pad) begin
                if (n_pad > plen) go_hdr = 1'b1;
                else begin
                    if (plen < {16'd0, i_packet_size}) begin
                        n_pad = n_pad + ({16'd0, i_packet_size} - plen);
                        n_len = {16'd0, i_packet_size};
                    end
                    if (pos + 33'd4 > {17'd0, i_packet_size}) go_hdr = 1'b1;
                    else begin
                        n_phase = PH_SEND; n_fbl = 3'd4; n_acc = '0; n_fidx = '0;
                    end
                end
            end
            if (go_dur) begin
                if (n_flags[0]) begin
                    if (pos + 33'd1 >= {17'd0, i_packet_size}) go_hdr = 1'b1;
                    else n_phase = PH_PCOUNT;
                end else begin
                    n_pl = 6'd1;
                    n_plt = 2'd2;
                    go_enter = 1'b1;
                end
            end

            // Payload header chain
            if (go_objnum) begin
                n = fsize(r_prop[5:4]);
                n_onum = '0;
                if (n == 3'd0) go_objoff = 1'b1;
                else if (rm < {29'd0, n}) go_pay = 1'b1;
                else begin
                    n_phase = PH_OBJNUM; n_fbl = n; n_acc = '0; n_fidx = '0;
                end
            end
            if (go_objoff) begin
                n = fsize(r_prop[3:2]);
                n_ooff = '0;
                if (n == 3'd0) go_replen = 1'b1;
                else if (rm < {29'd0, n}) go_pay = 1'b1;
                else begin
                    n_phase = PH_OBJOFF; n_fbl = n; n_acc = '0; n_fidx = '0;
                end
            end
            if (go_replen) begin
                n = fsize(r_prop[1:0]);
                n_rlen = '0;
                if (n == 3'd0) go_after_replen = 1'b1;
                else if (rm < {29'd0, n}) go_pay = 1'b1;
                else begin
                    n_phase = PH_REPLEN; n_fbl = n; n_acc = '0; n_fidx = '0;
                end
            end
            if (go_after_replen) begin
                if (i_start_from_first && !r_orgv) begin
                    n_org = r_send;
                    n_orgv = 1'b1;
                end
                if (rm < n_rlen) go_pay = 1'b1;
                else if (n_rlen > 32'd7) begin
                    n_ridx = '0; n_acc = '0; n_phase = PH_REP;
                end else if (n_rlen == 32'd0) begin
                    n_step = 8'd0;
                    tval = {1'b0, r_send};
                    go_after_time = 1'b1;
                end else if (n_rlen == 32'd1) begin
                    n_phase = PH_DELTA;
                end else if (rm < r_pad) begin
                    go_pay = 1'b1;
                end else begin
                    n_payl = '0;
                    if (rm == r_pad) go_enter = 1'b1;
                    else begin
                        n_sub = rm - r_pad;
                        n_phase = PH_SKIP;
                    end
                end
            end
            if (go_after_time) begin
                if (rm == 32'd0) go_pay = 1'b1;
                else begin
                    if (i_start_from_first) org = r_orgv ? r_org : r_send;
                    else org = i_preroll_start_ms;
                    orgsum = {1'b0, org} + {1'b0, i_preroll_ms};
                    n_pflag = {1'b0, r_send} > orgsum;
                    n_ptime = tval[32] ? 32'd0 : tval[31:0];
                    if (r_flags[0]) begin
                        n = fsize(r_plt);
                        if (n == 3'd0) begin
                            chk = '0; go_len_chk = 1'b1;
                        end else if (rm < {29'd0, n}) go_pay = 1'b1;
                        else begin
                            n_phase = PH_PLEN; n_fbl = n; n_acc = '0; n_fidx = '0;
                        end
                    end else if (rm < r_pad) go_pay = 1'b1;
                    else begin
                        chk = rm - r_pad;
                        go_len_chk = 1'b1;
                    end
                end
            end
            if (go_len_chk) begin
                if (chk == 32'd0 || chk > rm) go_pay = 1'b1;
                else begin
                    n_payl = chk;
                    n_sit = '0;
                    go_next_sub = 1'b1;
                end
            end
            if (go_next_sub) begin
                if (n_payl == 32'd0) go_enter = 1'b1;
                else if (n_rlen == 32'd1) n_phase = PH_SUBLEN;
                else begin
                    n_sub = n_payl;
                    n_payl = '0;
                    n_first = 1'b1;
                    n_phase = PH_DATA;
                end
            end
            if (go_enter) begin
                if (n_pl == 6'd0) go_disc = 1'b1;
                else if (rm == 32'd0) go_pay = 1'b1;
                else n_phase = PH_STREAM;
            end
            if (go_pay) begin
                if (ev == 2'd0) ev = 2'd3;
                go_disc = 1'b1;
            end
            if (go_disc) begin
                if (rm != 32'd0) begin
                    n_pbl = rm; n_phase = PH_DISCARD;
                end else n_phase = PH_EC;
            end
            if (go_hdr) begin
                ev = 2'd2;
                if (pos < {17'd0, i_packet_size}) begin
                    n_pbl = {16'd0, i_packet_size} - pos[31:0];
                    n_phase = PH_DISCARD;
                end else n_phase = PH_EC;
            end
        end
        n_pos = pos;
    end

    always_comb begin
        o_res_valid = i_valid && (ev != 2'd0);
        o_res = res_data;
        if (ev == 2'd2) begin
            o_res = '0;
            o_res.out_kind = KIND_HDR_ERR;
        end else if (ev == 2'd3) begin
            o_res = '0;
            o_res.out_kind = KIND_PAY_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EC;   r_pos <= '0;   r_len <= 32'd1024; r_pbl <= '0;
            r_acc <= '0;        r_fbl <= '0;   r_fidx <= '0;      r_flags <= '0;
            r_prop <= '0;       r_pad <= '0;   r_send <= '0;      r_pl <= '0;
            r_plt <= 2'd2;      r_payl <= '0;  r_sub <= '0;       r_sit <= '0;
            r_step <= '0;       r_ptime <= '0; r_stream <= '0;    r_key <= 1'b0;
            r_onum <= '0;       r_ooff <= '0;  r_rlen <= '0;      r_ridx <= '0;
            r_org <= '0;        r_orgv <= 1'b0; r_pflag <= 1'b0;  r_first <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase; r_pos <= n_pos; r_len <= n_len;   r_pbl <= n_pbl;
            r_acc <= n_acc;     r_fbl <= n_fbl; r_fidx <= n_fidx; r_flags <= n_flags;
            r_prop <= n_prop;   r_pad <= n_pad; r_send <= n_send; r_pl <= n_pl;
            r_plt <= n_plt;     r_payl <= n_payl; r_sub <= n_sub; r_sit <= n_sit;
            r_step <= n_step;   r_ptime <= n_ptime; r_stream <= n_stream;
            r_key <= n_key;     r_onum <= n_onum; r_ooff <= n_ooff;
            r_rlen <= n_rlen;   r_ridx <= n_ridx; r_org <= n_org; r_orgv <= n_orgv;
            r_pflag <= n_pflag; r_first <= n_first;
        end
    end

endmodule

### hw/rtl/adpd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpd_fifo: result queue
// Short queue between the parser and the result port.
// ----------------------------------------------------------------------------
module adpd_fifo
    import adpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_data,
    input  logic    i_rd,
    output t_result o_data,
    output logic    o_empty,
    output logic    o_full
);

    t_result          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_wr) - (QAW+1)'(i_rd);
        end
    end

endmodule

### hw/rtl/asf_data_packet_deframer.sv
`timescale 1ns / 1ps
// A result is queued as its byte is accepted; it shows when at the queue head.
// Throughput: one byte per cycle while full is low, with no parser stall.
// full rises only when the 4-entry result queue holds no free slot.
// Reset: synchronous, active low; parser to error-correction byte, queue empty,
// registers to packet_size 1024, preroll 0, start 0, start_from_first 1.
// ----------------------------------------------------------------------------
// asf_data_packet_deframer: ASF data packet deframer top level
// Byte parser in front, result queue behind.
// ----------------------------------------------------------------------------
module asf_data_packet_deframer
    import adpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_payload_byte,
    output logic [6:0]  o_stream_id,
    output logic        o_key_frame,
    output logic        o_frag_first,
    output logic        o_frag_last,
    output logic [31:0] o_object_number,
    output logic [31:0] o_object_offset,
    output logic [39:0] o_pts_ms,
    output logic [31:0] o_dts_ms,
    output logic [31:0] o_send_ms,
    output logic        o_preroll_done
);

    logic [15:0] r_packet_size;
    logic [31:0] r_preroll, r_preroll_start;
    logic        r_start_first;
    logic        acc, rd, res_valid;
    t_result     res, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_size <= 16'd1024;
            r_preroll <= '0;
            r_preroll_start <= '0;
            r_start_first <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PACKET_SIZE:   r_packet_size <= i_cfg_data[15:0];
                REG_PREROLL:       r_preroll <= i_cfg_data;
                REG_PREROLL_START: r_preroll_start <= i_cfg_data;
                REG_START_FIRST:   r_start_first <= i_cfg_data[0];
                default:           r_start_first <= r_start_first;
            endcase
        end
    end

    assign acc = push && !full;
    assign rd  = pop && !empty;

    adpd_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (acc),
        .i_byte             (i_data_byte),
        .i_packet_size      (r_packet_size),
        .i_preroll_ms       (r_preroll),
        .i_preroll_start_ms (r_preroll_start),
        .i_start_from_first (r_start_first),
        .o_res_valid        (res_valid),
        .o_res              (res)
    );

    adpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_data  (res),
        .i_rd    (rd),
        .o_data  (q_out),
        .o_empty (empty),
        .o_full  (full)
    );

    assign o_out_kind      = q_out.out_kind;
    assign o_payload_byte  = q_out.payload_byte;
    assign o_stream_id     = q_out.stream_id;
    assign o_key_frame     = q_out.key_frame;
    assign o_frag_first    = q_out.frag_first;
    assign o_frag_last     = q_out.frag_last;
    assign o_object_number = q_out.object_number;
    assign o_object_offset = q_out.object_offset;
    assign o_pts_ms        = q_out.pts_ms;
    assign o_dts_ms        = q_out.dts_ms;
    assign o_send_ms       = q_out.send_ms;
    assign o_preroll_done  = q_out.preroll_done;

    a_no_result_without_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> acc) else $error("result without accepted byte");
    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_kind != KIND_DATA) |-> (o_payload_byte == 8'd0 && o_pts_ms == '0))
        else $error("error result carries data");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_kind != 2'd3)) else $error("bad result kind");

endmodule

### test/tb_asf_data_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_asf_data_packet_deframer: self-checking bench for the ASF packet deframer
// Streams directed and generated ASF data packets through the byte port under
// several register settings. A scoreboard class predicts every result and
// checks each popped result field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_asf_data_packet_deframer;
    import adpd_pkg::*;

    class frame_scoreboard;
        int unsigned cfg_size, cfg_pre, cfg_start;
        bit          cfg_first;
        t_phase      phase;
        longint unsigned pos, plen, sub_time;
        int unsigned pkt_left, acc, fleft, fshift, flags, prop, pad, send;
        int unsigned pays_left, plt, pay_left, sub_left, tstep, ptime;
        int unsigned strm, key, objn, objo, replen, rep_idx, origin;
        bit          origin_ok, pflag, first_pend;
        int          ev;
        t_result     data_res;
        t_result     expected_q[$];
        int          errors, checked;

        function new();
            cfg_size = 1024; cfg_pre = 0; cfg_start = 0; cfg_first = 1;
            phase = PH_EC; pos = 0; plen = 1024; pkt_left = 0; acc = 0;
            fleft = 0; fshift = 0; flags = 0; prop = 0; pad = 0; send = 0;
            pays_left = 0; plt = 2; pay_left = 0; sub_left = 0; sub_time = 0;
            tstep = 0; ptime = 0; strm = 0; key = 0; objn = 0; objo = 0;
            replen = 0; rep_idx = 0; origin = 0; origin_ok = 0; pflag = 0;
            first_pend = 0; ev = 0; errors = 0; checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_PACKET_SIZE:   cfg_size = val[15:0];
                REG_PREROLL:       cfg_pre = val;
                REG_PREROLL_START: cfg_start = val;
                REG_START_FIRST:   cfg_first = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned fs(int unsigned t);
            case (t & 3)
                1: return 1;
                2: return 2;
                3: return 4;
                default: return 0;
            endcase
        endfunction

        function int unsigned rem();
            return pos < plen ? 32'(plen - pos) : 0;
        endfunction

        function void hdr_error();
            ev = 2;
            if (pos < cfg_size) begin
                pkt_left = 32'(cfg_size - pos);
                phase = PH_DISCARD;
            end else begin
                phase = PH_EC;
            end
        endfunction

        function void discard_to_end();
            int unsigned r;
            r = rem();
            if (r != 0) begin
                pkt_left = r;
                phase = PH_DISCARD;
            end else begin
                phase = PH_EC;
            end
        endfunction

        function void pay_error();
            if (ev == 0) ev = 3;
            discard_to_end();
        endfunction

        function void open_field(t_phase ph, int unsigned n);
            phase = ph; fleft = n; acc = 0; fshift = 0;
        endfunction

        function void enter_payload();
            if (pays_left == 0) begin
                discard_to_end();
                return;
            end
            if (rem() == 0) begin
                pay_error();
                return;
            end
            phase = PH_STREAM;
        endfunction

        function void start_skip(int unsigned n);
            pay_left = 0;
            if (n == 0) begin
                enter_payload();
                return;
            end
            sub_left = n;
            phase = PH_SKIP;
        endfunction

        function void next_sub();
            if (pay_left == 0) begin
                enter_payload();
                return;
            end
            if (replen == 1) begin
                phase = PH_SUBLEN;
            end else begin
                sub_left = pay_left; pay_left = 0; first_pend = 1; phase = PH_DATA;
            end
        endfunction

        function void check_len(int unsigned len);
            if (len == 0 || len > rem()) begin
                pay_error();
                return;
            end
            pay_left = len; sub_time = 0;
            next_sub();
        endfunction

        function void after_time(longint t);
            longint unsigned org;
            int unsigned n;
            if (rem() == 0) begin
                pay_error();
                return;
            end
            if (cfg_first) org = origin_ok ? origin : send;
            else org = cfg_start;
            pflag = longint'({32'b0, send}) > org + {32'b0, cfg_pre};
            ptime = t < 0 ? 0 : 32'(t);
            if (flags[0]) begin
                n = fs(plt);
                if (n == 0) check_len(0);
                else if (rem() < n) pay_error();
                else open_field(PH_PLEN, n);
            end else if (rem() < pad) begin
                pay_error();
            end else begin
                check_len(rem() - pad);
            end
        endfunction

        function void after_replen();
            int unsigned r;
            if (cfg_first && !origin_ok) begin
                origin = send; origin_ok = 1;
            end
            r = rem();
            if (r < replen) begin
                pay_error();
                return;
            end
            if (replen > 7) begin
                rep_idx = 0; acc = 0; phase = PH_REP;
            end else if (replen == 0) begin
                tstep = 0;
                after_time(longint'({32'b0, send}));
            end else if (replen == 1) begin
                phase = PH_DELTA;
            end else if (r < pad) begin
                pay_error();
            end else begin
                start_skip(r - pad);
            end
        endfunction

        function void enter_field(t_phase ph, int unsigned n);
            if (rem() < n) pay_error();
            else open_field(ph, n);
        endfunction

        function void enter_replen();
            replen = 0;
            if (fs(prop) == 0) after_replen();
            else enter_field(PH_REPLEN, fs(prop));
        endfunction

        function void enter_objoff();
            objo = 0;
            if (fs(prop >> 2) == 0) enter_replen();
            else enter_field(PH_OBJOFF, fs(prop >> 2));
        endfunction

        function void enter_objnum();
            objn = 0;
            if (fs(prop >> 4) == 0) enter_objoff();
            else enter_field(PH_OBJNUM, fs(prop >> 4));
        endfunction

        function void hdr_field(t_phase ph, int unsigned n);
            if (pos + n > cfg_size) hdr_error();
            else open_field(ph, n);
        endfunction

        function void after_pad();
            if (pad > plen) begin
                hdr_error();
                return;
            end
            if (plen < cfg_size) begin
                pad += 32'(cfg_size - plen);
                plen = cfg_size;
            end
            if (pos + 4 > cfg_size) begin
                hdr_error();
                return;
            end
            open_field(PH_SEND, 4);
        endfunction

        function void enter_pad();
            pad = 0;
            if (fs(flags >> 3) == 0) after_pad();
            else hdr_field(PH_PAD, fs(flags >> 3));
        endfunction

        function void enter_seq();
            if (fs(flags >> 1) == 0) enter_pad();
            else hdr_field(PH_SEQ, fs(flags >> 1));
        endfunction

        function void advance_index();
            sub_time += tstep;
            if (sub_time > MAX40) sub_time = MAX40;
        endfunction

        function void field_done();
            case (phase)
                PH_LEN: begin
                    plen = acc; enter_seq();
                end
                PH_SEQ: enter_pad();
                PH_PAD: begin
                    pad = acc; after_pad();
                end
                PH_SEND: begin
                    send = acc; open_field(PH_DUR, 2);
                end
                PH_DUR: begin
                    if (flags[0]) begin
                        if (pos + 1 >= cfg_size) hdr_error();
                        else phase = PH_PCOUNT;
                    end else begin
                        pays_left = 1; plt = 2; enter_payload();
                    end
                end
                PH_OBJNUM: begin
                    objn = acc; enter_objoff();
                end
                PH_OBJOFF: begin
                    objo = acc; enter_replen();
                end
                PH_REPLEN: begin
                    replen = acc; after_replen();
                end
                default: check_len(acc);
            endcase
        endfunction

        function void note_byte(logic [7:0] data);
            int unsigned b;
            longint unsigned pts;
            t_result r;
            b = data;
            ev = 0;
            if (phase == PH_EC) begin
                pos = 0; plen = cfg_size;
            end
            pos++;
            case (phase)
                PH_EC: begin
                    if (b[7]) begin
                        if (b[6:5] != 0 || b[4] || b[3:0] != 4'h2) hdr_error();
                        else begin
                            phase = PH_ECDATA; fleft = 2;
                        end
                    end else if (cfg_size <= 2) begin
                        hdr_error();
                    end else begin
                        flags = b; phase = PH_PROP;
                    end
                end
                PH_ECDATA: begin
                    if (fleft != 0) fleft--;
                    if (fleft == 0) begin
                        if (pos + 2 >= cfg_size) hdr_error();
                        else phase = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    flags = b; phase = PH_PROP;
                end
                PH_PROP: begin
                    prop = b;
                    plen = cfg_size;
                    if (fs(flags >> 5) == 0) enter_seq();
                    else hdr_field(PH_LEN, fs(flags >> 5));
                end
                PH_PCOUNT: begin
                    pays_left = b & 8'h3f; plt = (b >> 6) & 3;
                    enter_payload();
                end
                PH_STREAM: begin
                    key = b >> 7; strm = b & 8'h7f;
                    if (pays_left != 0) pays_left--;
                    enter_objnum();
                end
                PH_REP: begin
                    if (rep_idx >= 4 && rep_idx < 8) acc |= b << (8 * (rep_idx - 4));
                    rep_idx++;
                    if (rep_idx >= replen) begin
                        tstep = 0;
                        after_time(longint'({32'b0, acc}) - longint'({32'b0, cfg_pre}));
                    end
                end
                PH_DELTA: begin
                    tstep = b;
                    pts = objo;
                    objo = 0;
                    after_time(longint'(pts) - longint'({32'b0, cfg_pre}));
                end
                PH_SUBLEN: begin
                    if (pay_left != 0) pay_left--;
                    if (b > pay_left) begin
                        start_skip(pay_left);
                    end else begin
                        pay_left -= b; sub_left = b;
                        if (b == 0) begin
                            advance_index(); next_sub();
                        end else begin
                            first_pend = 1; phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    pts = longint'({32'b0, ptime}) + sub_time;
                    if (pts > MAX40) pts = MAX40;
                    data_res = '0;
                    data_res.out_kind = KIND_DATA;
                    data_res.payload_byte = b;
                    data_res.stream_id = strm;
                    data_res.key_frame = key;
                    data_res.frag_first = first_pend;
                    data_res.frag_last = sub_left <= 1;
                    data_res.object_number = objn;
                    data_res.object_offset = objo;
                    data_res.pts_ms = pts[39:0];
                    data_res.dts_ms = ptime;
                    data_res.send_ms = send;
                    data_res.preroll_done = pflag;
                    ev = 1;
                    first_pend = 0;
                    if (sub_left != 0) sub_left--;
                    if (sub_left == 0) begin
                        advance_index(); next_sub();
                    end
                end
                PH_SKIP: begin
                    if (sub_left != 0) sub_left--;
                    if (sub_left == 0) enter_payload();
                end
                PH_DISCARD: begin
                    if (pkt_left != 0) pkt_left--;
                    if (pkt_left == 0) phase = PH_EC;
                end
                default: begin
                    if (fshift < 32) acc |= b << fshift;
                    fshift += 8;
                    if (fleft != 0) fleft--;
                    if (fleft == 0) field_done();
                end
            endcase
            if (ev == 1) begin
                expected_q.push_back(data_res);
            end else if (ev != 0) begin
                r = '0;
                r.out_kind = ev == 2 ? KIND_HDR_ERR : KIND_PAY_ERR;
                expected_q.push_back(r);
            end
        endfunction

        function void cmp(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_q.size() == 0) begin
                $error("unexpected result, kind %0d", got.out_kind);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            cmp("out_kind", e.out_kind, got.out_kind);
            cmp("payload_byte", e.payload_byte, got.payload_byte);
            cmp("stream_id", e.stream_id, got.stream_id);
            cmp("key_frame", e.key_frame, got.key_frame);
            cmp("frag_first", e.frag_first, got.frag_first);
            cmp("frag_last", e.frag_last, got.frag_last);
            cmp("object_number", e.object_number, got.object_number);
            cmp("object_offset", e.object_offset, got.object_offset);
            cmp("pts_ms", e.pts_ms, got.pts_ms);
            cmp("dts_ms", e.dts_ms, got.dts_ms);
            cmp("send_ms", e.send_ms, got.send_ms);
            cmp("preroll_done", e.preroll_done, got.preroll_done);
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_SETTINGS   = 6;

    logic        i_clk, i_rst_n, push, pop, i_cfg_we;
    logic        full, empty;
    logic [7:0]  i_data_byte;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    t_result     got;

    frame_scoreboard sb;
    bit  quiet, hold_req;
    int  bytes_sent, idle_cycles;

    asf_data_packet_deframer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_data_byte(i_data_byte), .empty(empty), .pop(pop),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_out_kind(got.out_kind), .o_payload_byte(got.payload_byte),
        .o_stream_id(got.stream_id), .o_key_frame(got.key_frame),
        .o_frag_first(got.frag_first), .o_frag_last(got.frag_last),
        .o_object_number(got.object_number), .o_object_offset(got.object_offset),
        .o_pts_ms(got.pts_ms), .o_dts_ms(got.dts_ms), .o_send_ms(got.send_ms),
        .o_preroll_done(got.preroll_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request side
    task automatic send_byte(logic [7:0] b);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [15:0] size, logic [31:0] pre, logic [31:0] start,
                             logic first);
        logic [31:0] vals [4];
        vals[REG_PACKET_SIZE] = size;
        vals[REG_PREROLL] = pre;
        vals[REG_PREROLL_START] = start;
        vals[REG_START_FIRST] = first;
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 2'(i);
            i_cfg_data <= vals[i];
            sb.write_reg(2'(i), vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic void put_le(ref logic [7:0] q[$], input int unsigned v,
                                   input int unsigned n);
        for (int i = 0; i < n; i++) q.push_back(8'(v >> (8 * i)));
    endfunction

    function automatic void build_packet(int psize, ref logic [7:0] q[$]);
        int unsigned multi, ont, oot, rlt, plt, padt, lent, padv, lenv, effpad;
        int unsigned npay, rv, k;
        int room, dlen, left;
        if ($urandom_range(0, 9) == 0) begin
            repeat (psize) q.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            q.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) | 8'h80 : 8'h82);
            put_le(q, $urandom, 2);
        end
        multi = $urandom_range(0, 1);
        padt = $urandom_range(0, 2);
        lent = $urandom_range(0, 2);
        q.push_back(8'(multi | ($urandom_range(0, 3) << 1) | (padt << 3) | (lent << 5)));
        ont = $urandom_range(0, 3);
        oot = $urandom_range(0, 3);
        rlt = $urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : 1;
        q.push_back(8'(rlt | (oot << 2) | (ont << 4) | ($urandom_range(0, 3) << 6)));
        padv = padt != 0 ? $urandom_range(0, 3) : 0;
        lenv = $urandom_range(0, 3) == 0 ? psize - $urandom_range(0, 4) : psize;
        if (lent == 1 && lenv > 255) lenv = $urandom_range(0, 255);
        put_le(q, lenv, lent == 0 ? 0 : lent);
        put_le(q, $urandom, $urandom_range(0, 2));
        q.push_back(8'($urandom));
        put_le(q, padv, padt);
        put_le(q, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000), 4);
        put_le(q, $urandom, 2);
        effpad = padv + (lenv < psize ? psize - lenv : 0);
        npay = 1;
        plt = 2;
        if (multi) begin
            npay = $urandom_range(1, 3);
            plt = $urandom_range(1, 2);
            q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'((plt << 6) | npay));
        end
        for (int p = 0; p < npay; p++) begin
            q.push_back(8'($urandom));
            put_le(q, $urandom, ont == 3 ? 4 : ont);
            put_le(q, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000),
                   oot == 3 ? 4 : oot);
            k = $urandom_range(0, 19);
            rv = k < 11 ? 8 : k < 16 ? 1 : k < 18 ? 0 : $urandom_range(2, 7);
            if (rlt == 0) rv = 0;
            put_le(q, rv, rlt == 3 ? 4 : rlt);
            if (rv == 8) begin
                put_le(q, $urandom, 4);
                put_le(q, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000), 4);
            end else begin
                repeat (rv) q.push_back(8'($urandom));
            end
            room = psize - int'(effpad) - q.size() - (multi ? int'(plt) : 0);
            dlen = p == npay - 1 ? room : $urandom_range(1, room > 2 ? room / 2 : 1);
            if (dlen < 1) dlen = 1;
            if (multi) put_le(q, dlen, plt);
            if (rv == 1) begin
                left = dlen;
                while (left > 0) begin
                    k = $urandom_range(0, left - 1 < 12 ? left - 1 : 12);
                    q.push_back(8'(k));
                    repeat (k) q.push_back(8'($urandom));
                    left -= k + 1;
                end
            end else begin
                repeat (dlen) q.push_back(8'($urandom));
            end
        end
        while (q.size() < psize) q.push_back(8'($urandom));
    endfunction

    // result side
    initial begin
        int idle_left, hold_left;
        idle_left = 0;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty && i_rst_n) sb.check_result(got);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (quiet) begin
                pop <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                pop <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                idle_left = $urandom_range(0, 3);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || i_cfg_we || !i_rst_n) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] sizes [NUM_SETTINGS];
        logic [31:0] pres [NUM_SETTINGS];
        logic [31:0] starts [NUM_SETTINGS];
        logic        firsts [NUM_SETTINGS];
        logic [7:0]  directed [$];
        logic [7:0]  pkt [$];
        int          budget;
        sizes = '{16'd8, 16'd40, 16'd64, 16'd200, 16'd65535, 16'd48};
        pres = '{32'd0, 32'd500, 32'hFFFF_FFFF, 32'd0, 32'd100, 32'd1000};
        starts = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1500, 32'd0, 32'd0};
        firsts = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        directed = '{8'hA2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h82, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00,
                     8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
        sb = new();
        quiet = 1'b0;
        hold_req = 1'b0;
        bytes_sent = 0;
        push = 1'b0;
        i_data_byte = 8'h00;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_PACKET_SIZE;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            write_cfg(sizes[s], pres[s], starts[s], firsts[s]);
            if (s == 0) begin
                foreach (directed[i]) send_byte(directed[i]);
            end
            if (s == 1) hold_req = 1'b1;
            if (s == NUM_SETTINGS - 1) quiet = 1'b1;
            budget = sizes[s] == 16'd65535 ? 90 : 170;
            while (budget > 0) begin
                pkt.delete();
                build_packet(sizes[s] == 16'd65535 ? 120 : sizes[s], pkt);
                foreach (pkt[i]) begin
                    if (budget > 0) send_byte(pkt[i]);
                    budget--;
                end
            end
            drain();
        end
        $display("tb: %0d bytes pushed, %0d results checked across %0d register settings",
                 bytes_sent, sb.checked, NUM_SETTINGS);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
